// File: rtl/core/hlou_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlou_pkg
// Shared constants for the hex lattice opinion update block: cell codes,
// command codes, register indexes and the neighbour step tables.
// ----------------------------------------------------------------------------
package hlou_pkg;

  typedef logic [1:0] cell_t;
  typedef logic [1:0] step_t;

  localparam cell_t CELL_EMPTY    = 2'd0;
  localparam cell_t CELL_MODERATE = 2'd1;
  localparam cell_t CELL_RADICAL  = 2'd2;
  localparam cell_t CELL_INVALID  = 2'd3;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 17;
  localparam int CountW    = 17;

  localparam logic [CfgIndexW-1:0] REG_CONTAGION = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_MEDIA     = 2'd1;

  localparam logic [16:0] CONTAGION_RESET = 17'd19661;
  localparam logic [16:0] MEDIA_RESET     = 17'd0;

  localparam logic [2:0] DIR_LAST = 3'd5;

  localparam step_t STEP_ZERO = 2'd0;
  localparam step_t STEP_INC  = 2'd1;
  localparam step_t STEP_DEC  = 2'd2;

  localparam step_t ROW_STEP [6] = '{STEP_ZERO, STEP_DEC, STEP_DEC,
                                     STEP_ZERO, STEP_INC, STEP_INC};
  localparam step_t COL_STEP_EVEN [6] = '{STEP_INC, STEP_ZERO, STEP_DEC,
                                          STEP_DEC, STEP_DEC, STEP_ZERO};
  localparam step_t COL_STEP_ODD [6] = '{STEP_INC, STEP_INC, STEP_ZERO,
                                         STEP_DEC, STEP_ZERO, STEP_INC};

endpackage

// File: rtl/core/hex_lattice_opinion_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_lattice_opinion_update
// Periodic offset-row triangular lattice of opinion cells held in one
// on-chip memory (one write port, two registered read ports). Each beat is
// a cell load or an update event; each gives one result beat with the
// touched cells and the running moderate and radical counts.
//
//   channel | signals                                           | dir
//   --------+---------------------------------------------------+----
//   input   | in_valid in_ready command row column direction    | in
//           | draw load_value                                   |
//   output  | out_valid out_ready active_index active_state     | out
//           | neighbor_index neighbor_state moderate_count      |
//           | radical_count                                     |
//   config  | cfg_valid cfg_ready cfg_index cfg_data            | in
//
// For each item, the accept cycle reads the active and neighbour cells, and
// the next cycle writes back at most one cell and loads the result.
// After reset a clearing pass writes LATTICE_SIZE*LATTICE_SIZE cells, one a
// cycle, with in_ready low; config beats are taken throughout.
// A result waiting on out_ready holds off only the next accept.
// ----------------------------------------------------------------------------
module hex_lattice_opinion_update #(
  parameter int LATTICE_SIZE = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [7:0]                       row,
  input  logic [7:0]                       column,
  input  logic [2:0]                       direction,
  input  logic [15:0]                      draw,
  input  logic [1:0]                       load_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      active_index,
  output logic [1:0]                       active_state,
  output logic [15:0]                      neighbor_index,
  output logic [1:0]                       neighbor_state,
  output logic [16:0]                      moderate_count,
  output logic [16:0]                      radical_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hlou_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [hlou_pkg::CfgDataW-1:0]    cfg_data
);

  localparam int CellCount = LATTICE_SIZE * LATTICE_SIZE;
  localparam int CW        = $clog2(LATTICE_SIZE);
  localparam int IDX_W     = $clog2(CellCount);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration
  logic [16:0] contagion;
  logic [16:0] media;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      contagion <= hlou_pkg::CONTAGION_RESET;
      media     <= hlou_pkg::MEDIA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hlou_pkg::REG_CONTAGION: contagion <= cfg_data;
        hlou_pkg::REG_MEDIA:     media     <= cfg_data;
        default: ;
      endcase
    end
  end

  // row and column reduction table
  logic [CW-1:0] mod_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = CW'(g % LATTICE_SIZE);
  end

  function automatic logic [CW-1:0] wrap_step(logic [CW-1:0] v, hlou_pkg::step_t s);
    logic [CW-1:0] r;
    r = v;
    case (s)
      hlou_pkg::STEP_INC: r = (v == CW'(LATTICE_SIZE - 1)) ? '0 : v + 1'b1;
      hlou_pkg::STEP_DEC: r = (v == '0) ? CW'(LATTICE_SIZE - 1) : v - 1'b1;
      default:            r = v;
    endcase
    return r;
  endfunction

  // address generation from the input beat
  logic [CW-1:0]    r_mod;
  logic [CW-1:0]    c_mod;
  logic [2:0]       dir_sat;
  hlou_pkg::step_t  rs;
  hlou_pkg::step_t  cs;
  logic [CW-1:0]    nr;
  logic [CW-1:0]    nc;
  logic [IDX_W-1:0] act_addr;
  logic [IDX_W-1:0] nb_addr;

  always_comb begin
    r_mod   = mod_tab[row];
    c_mod   = mod_tab[column];
    dir_sat = (direction > hlou_pkg::DIR_LAST) ? hlou_pkg::DIR_LAST : direction;
    rs      = hlou_pkg::ROW_STEP[dir_sat];
    cs      = r_mod[0] ? hlou_pkg::COL_STEP_ODD[dir_sat] : hlou_pkg::COL_STEP_EVEN[dir_sat];
    nr      = wrap_step(r_mod, rs);
    nc      = wrap_step(c_mod, cs);
    act_addr = IDX_W'(IDX_W'(r_mod) * IDX_W'(LATTICE_SIZE)) + IDX_W'(c_mod);
    nb_addr  = IDX_W'(IDX_W'(nr) * IDX_W'(LATTICE_SIZE)) + IDX_W'(nc);
  end

  logic in_beat;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_beat  = in_valid && in_ready;

  // latched item
  logic             cmd_q;
  logic [IDX_W-1:0] act_q;
  logic [IDX_W-1:0] nb_q;
  logic [15:0]      draw_q;
  hlou_pkg::cell_t  load_q;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_q  <= command;
      act_q  <= act_addr;
      nb_q   <= nb_addr;
      draw_q <= draw;
      load_q <= (load_value == hlou_pkg::CELL_INVALID) ? hlou_pkg::CELL_EMPTY : load_value;
    end
  end

  // lattice memory
  hlou_pkg::cell_t  cells [CellCount];
  hlou_pkg::cell_t  act_rd;
  hlou_pkg::cell_t  nb_rd;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  hlou_pkg::cell_t  mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    act_rd <= cells[act_addr];
    nb_rd  <= cells[nb_addr];
  end

  // clearing pass
  logic [IDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // event rules
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  hlou_pkg::cell_t  wr_old;
  hlou_pkg::cell_t  wr_new;
  logic [17:0]      thr_sum;
  hlou_pkg::cell_t  act_new;
  hlou_pkg::cell_t  nb_new;

  always_comb begin
    thr_sum = {1'b0, contagion} + {1'b0, media};
    wr_en   = 1'b0;
    wr_addr = act_q;
    wr_old  = act_rd;
    wr_new  = act_rd;
    if (cmd_q == hlou_pkg::CMD_LOAD) begin
      wr_en  = 1'b1;
      wr_new = load_q;
    end else if (act_rd != hlou_pkg::CELL_EMPTY) begin
      if ({1'b0, draw_q} < contagion) begin
        if (act_rd == hlou_pkg::CELL_RADICAL && nb_rd == hlou_pkg::CELL_MODERATE) begin
          wr_en   = 1'b1;
          wr_addr = nb_q;
          wr_old  = nb_rd;
          wr_new  = hlou_pkg::CELL_RADICAL;
        end
      end else if ({2'b00, draw_q} < thr_sum) begin
        if (act_rd == hlou_pkg::CELL_MODERATE) begin
          wr_en  = 1'b1;
          wr_new = hlou_pkg::CELL_RADICAL;
        end
      end else if (act_rd == hlou_pkg::CELL_RADICAL) begin
        wr_en  = 1'b1;
        wr_new = hlou_pkg::CELL_MODERATE;
      end
    end
    act_new = (wr_en && wr_addr == act_q) ? wr_new : act_rd;
    nb_new  = (wr_en && wr_addr == nb_q && cmd_q == hlou_pkg::CMD_UPDATE) ? wr_new : nb_rd;
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = hlou_pkg::CELL_EMPTY;
    end else begin
      mem_we    = (state == ST_EXEC) && wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_new;
    end
  end

  // running counts
  logic [16:0] mod_cnt;
  logic [16:0] rad_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
      rad_cnt <= '0;
    end else if (state == ST_EXEC && wr_en) begin
      mod_cnt <= mod_cnt - 17'(wr_old == hlou_pkg::CELL_MODERATE)
                         + 17'(wr_new == hlou_pkg::CELL_MODERATE);
      rad_cnt <= rad_cnt - 17'(wr_old == hlou_pkg::CELL_RADICAL)
                         + 17'(wr_new == hlou_pkg::CELL_RADICAL);
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == IDX_W'(CellCount - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_beat) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EXEC) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      active_index   <= 16'(act_q);
      active_state   <= act_new;
      neighbor_index <= (cmd_q == hlou_pkg::CMD_UPDATE) ? 16'(nb_q) : 16'd0;
      neighbor_state <= (cmd_q == hlou_pkg::CMD_UPDATE) ? nb_new : hlou_pkg::CELL_EMPTY;
      moderate_count <= mod_cnt - 17'(wr_en && wr_old == hlou_pkg::CELL_MODERATE)
                                + 17'(wr_en && wr_new == hlou_pkg::CELL_MODERATE);
      radical_count  <= rad_cnt - 17'(wr_en && wr_old == hlou_pkg::CELL_RADICAL)
                                + 17'(wr_en && wr_new == hlou_pkg::CELL_RADICAL);
    end
  end

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> state == ST_EXEC)
    else $error("accepted beat not followed by execute cycle");

  a_write_target: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && mem_we) |-> (mem_waddr == act_q || mem_waddr == nb_q))
    else $error("write back outside the active or neighbour cell");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, mod_cnt} + {1'b0, rad_cnt}) <= 18'(CellCount))
    else $error("cell counts exceed lattice size");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result still pending");
`endif

endmodule

// File: tb/tb_hex_lattice_opinion_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_lattice_opinion_update
// Drives load and update events into the opinion lattice and checks every
// result beat against a behavioural mirror of the lattice, its counts and
// the thresholds, or typed table values. A short directed table is run
// first, then random phases under several threshold settings, including the
// saturating ones. Random events mostly land on a small patch at the wrap
// corner so that updates find occupied cells. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_hex_lattice_opinion_update;

  localparam int SIZE = 128;

  localparam logic [2:0] DIR_RIGHT      = 3'd0;
  localparam logic [2:0] DIR_UP_RIGHT   = 3'd1;
  localparam logic [2:0] DIR_UP_LEFT    = 3'd2;
  localparam logic [2:0] DIR_LEFT       = 3'd3;
  localparam logic [2:0] DIR_DOWN_LEFT  = 3'd4;
  localparam logic [2:0] DIR_DOWN_RIGHT = 3'd5;
  localparam logic [2:0] DIR_OVER_LO    = 3'd6;
  localparam logic [2:0] DIR_OVER_HI    = 3'd7;

  typedef struct packed {
    logic        command;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [2:0]  direction;
    logic [15:0] draw;
    logic [1:0]  load_value;
  } event_t;

  typedef struct packed {
    logic [15:0]     active_index;
    hlou_pkg::cell_t active_state;
    logic [15:0]     neighbor_index;
    hlou_pkg::cell_t neighbor_state;
    logic [16:0]     moderate_count;
    logic [16:0]     radical_count;
  } outcome_t;

  typedef struct packed {
    event_t   ev;
    logic     typed;
    outcome_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = hlou_pkg::CMD_LOAD;
  logic [7:0]  row = '0;
  logic [7:0]  column = '0;
  logic [2:0]  direction = DIR_RIGHT;
  logic [15:0] draw = '0;
  logic [1:0]  load_value = hlou_pkg::CELL_EMPTY;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] active_index;
  logic [1:0]  active_state;
  logic [15:0] neighbor_index;
  logic [1:0]  neighbor_state;
  logic [16:0] moderate_count;
  logic [16:0] radical_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [hlou_pkg::CfgIndexW-1:0] cfg_index = hlou_pkg::REG_CONTAGION;
  logic [hlou_pkg::CfgDataW-1:0]  cfg_data = '0;

  hex_lattice_opinion_update #(
    .LATTICE_SIZE(SIZE)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .row(row),
    .column(column),
    .direction(direction),
    .draw(draw),
    .load_value(load_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .active_index(active_index),
    .active_state(active_state),
    .neighbor_index(neighbor_index),
    .neighbor_state(neighbor_state),
    .moderate_count(moderate_count),
    .radical_count(radical_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // mirror of the lattice, counts and thresholds
  hlou_pkg::cell_t cell_mirror [SIZE*SIZE];
  logic [16:0]     moderates_seen;
  logic [16:0]     radicals_seen;
  logic [16:0]     contagion_thr;
  logic [16:0]     media_thr;

  outcome_t  pending_outcomes [$];
  plan_row_t plan [$];

  int fail_count = 0;
  int results_seen = 0;
  int events_sent = 0;
  int loads_seen = 0;
  int occupied_updates = 0;
  int rule_rewrites = 0;
  int settings_used = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;

  function automatic void store_cell(int idx, hlou_pkg::cell_t value);
    if (cell_mirror[idx] == hlou_pkg::CELL_MODERATE) moderates_seen = moderates_seen - 17'd1;
    else if (cell_mirror[idx] == hlou_pkg::CELL_RADICAL) radicals_seen = radicals_seen - 17'd1;
    cell_mirror[idx] = value;
    if (value == hlou_pkg::CELL_MODERATE) moderates_seen = moderates_seen + 17'd1;
    else if (value == hlou_pkg::CELL_RADICAL) radicals_seen = radicals_seen + 17'd1;
  endfunction

  function automatic int neighbour_of(int r, int c, logic [2:0] dir);
    int  dr;
    int  dc;
    bit  odd;
    odd = r[0];
    case (dir)
      DIR_RIGHT: begin
        dr = 0;
        dc = 1;
      end
      DIR_UP_RIGHT: begin
        dr = -1;
        dc = odd ? 1 : 0;
      end
      DIR_UP_LEFT: begin
        dr = -1;
        dc = odd ? 0 : -1;
      end
      DIR_LEFT: begin
        dr = 0;
        dc = -1;
      end
      DIR_DOWN_LEFT: begin
        dr = 1;
        dc = odd ? 0 : -1;
      end
      default: begin
        dr = 1;
        dc = odd ? 1 : 0;
      end
    endcase
    return ((r + SIZE + dr) % SIZE) * SIZE + (c + SIZE + dc) % SIZE;
  endfunction

  function automatic outcome_t predict_event(event_t ev);
    int              r;
    int              c;
    int              act;
    int              nb;
    hlou_pkg::cell_t act_val;
    hlou_pkg::cell_t nb_val;
    logic [17:0]     thr_sum;
    outcome_t        o;
    r = int'(ev.row) % SIZE;
    c = int'(ev.column) % SIZE;
    act = r * SIZE + c;
    nb = 0;
    nb_val = hlou_pkg::CELL_EMPTY;
    if (ev.command == hlou_pkg::CMD_LOAD) begin
      loads_seen++;
      store_cell(act, (ev.load_value == hlou_pkg::CELL_INVALID) ?
                      hlou_pkg::CELL_EMPTY : ev.load_value);
    end else begin
      nb = neighbour_of(r, c, ev.direction);
      act_val = cell_mirror[act];
      thr_sum = {1'b0, contagion_thr} + {1'b0, media_thr};
      if (act_val != hlou_pkg::CELL_EMPTY) begin
        occupied_updates++;
        if ({1'b0, ev.draw} < contagion_thr) begin
          if (act_val == hlou_pkg::CELL_RADICAL &&
              cell_mirror[nb] == hlou_pkg::CELL_MODERATE) begin
            store_cell(nb, hlou_pkg::CELL_RADICAL);
            rule_rewrites++;
          end
        end else if ({2'b00, ev.draw} < thr_sum) begin
          if (act_val == hlou_pkg::CELL_MODERATE) begin
            store_cell(act, hlou_pkg::CELL_RADICAL);
            rule_rewrites++;
          end
        end else if (act_val == hlou_pkg::CELL_RADICAL) begin
          store_cell(act, hlou_pkg::CELL_MODERATE);
          rule_rewrites++;
        end
      end
      nb_val = cell_mirror[nb];
    end
    o.active_index = act[15:0];
    o.active_state = cell_mirror[act];
    o.neighbor_index = nb[15:0];
    o.neighbor_state = nb_val;
    o.moderate_count = moderates_seen;
    o.radical_count = radicals_seen;
    return o;
  endfunction

  function automatic event_t random_event();
    event_t      ev;
    logic [31:0] rnd;
    logic [31:0] spot;
    logic [17:0] thr_sum;
    rnd = $urandom;
    ev.command = (rnd[3:0] < 4'd5) ? hlou_pkg::CMD_LOAD : hlou_pkg::CMD_UPDATE;
    if (rnd[8:4] == 5'd0) begin
      rnd = $urandom;
      ev.row = rnd[7:0];
      ev.column = rnd[15:8];
    end else begin
      // patch of 5 x 5 cells around the wrap corner, sometimes with bit 7 set
      spot = ($urandom_range(0, 4) + 32'd126) % 32'd128;
      ev.row = spot[7:0];
      spot = ($urandom_range(0, 4) + 32'd126) % 32'd128;
      ev.column = spot[7:0];
      rnd = $urandom;
      if (rnd[1:0] == 2'd0) ev.row[7] = 1'b1;
      if (rnd[3:2] == 2'd0) ev.column[7] = 1'b1;
    end
    rnd = $urandom;
    thr_sum = {1'b0, contagion_thr} + {1'b0, media_thr};
    case (rnd[19:16])
      4'd0: ev.draw = contagion_thr[15:0] - 16'd1;
      4'd1: ev.draw = contagion_thr[15:0];
      4'd2: ev.draw = thr_sum[15:0] - 16'd1;
      4'd3: ev.draw = thr_sum[15:0];
      default: ev.draw = rnd[15:0];
    endcase
    rnd = $urandom;
    ev.direction = rnd[2:0];
    if (rnd[5:3] == 3'd0) ev.load_value = rnd[7:6];
    else ev.load_value = rnd[6] ? hlou_pkg::CELL_RADICAL : hlou_pkg::CELL_MODERATE;
    return ev;
  endfunction

  task automatic send_event(input event_t ev, input logic typed, input outcome_t typed_want);
    outcome_t    predicted;
    logic [31:0] gap;
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {command, row, column, direction, draw, load_value} <= ev;
    do @(posedge clk); while (!in_ready);
    predicted = predict_event(ev);
    pending_outcomes.push_back(typed ? typed_want : predicted);
    events_sent++;
  endtask

  task automatic program_thresholds(input logic [16:0] contagion, input logic [16:0] media);
    cfg_valid <= 1'b1;
    cfg_index <= hlou_pkg::REG_CONTAGION;
    cfg_data <= contagion;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= hlou_pkg::REG_MEDIA;
    cfg_data <= media;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    contagion_thr = contagion;
    media_thr = media;
    settings_used++;
  endtask

  task automatic run_phase(input logic [16:0] contagion, input logic [16:0] media,
                           input int count, input int tx_pct, input int rx_pct);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    program_thresholds(contagion, media);
    tx_gap_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_event(random_event(), 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [16:0] want, input logic [16:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d",
                 results_seen, name, want, got);
    end
  endtask

  // result side: random stall bursts, then compare against the oldest pending outcome
  outcome_t oldest;

  always @(posedge clk) begin
    if (rx_hold > 0) rx_hold--;
    else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct)
      rx_hold = $urandom_range(1, 5);
    out_ready <= (rx_hold == 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d arrived with nothing outstanding", results_seen);
      end else begin
        oldest = pending_outcomes.pop_front();
        check_field("active_index", 17'(oldest.active_index), 17'(active_index));
        check_field("active_state", 17'(oldest.active_state), 17'(active_state));
        check_field("neighbor_index", 17'(oldest.neighbor_index), 17'(neighbor_index));
        check_field("neighbor_state", 17'(oldest.neighbor_state), 17'(neighbor_state));
        check_field("moderate_count", oldest.moderate_count, moderate_count);
        check_field("radical_count", oldest.radical_count, radical_count);
      end
      results_seen++;
    end
  end

  initial begin
    #5000000;
    $display("FAIL hex_lattice_opinion_update");
    $finish;
  end

  initial begin
    logic [31:0] rnd_c;
    logic [31:0] rnd_m;
    int          guard;

    foreach (cell_mirror[i]) cell_mirror[i] = hlou_pkg::CELL_EMPTY;
    moderates_seen = '0;
    radicals_seen = '0;
    contagion_thr = hlou_pkg::CONTAGION_RESET;
    media_thr = hlou_pkg::MEDIA_RESET;

    // wrap corner, both row parities, every direction, out of range codes
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd0, 8'd0, DIR_RIGHT, 16'd0,
                       hlou_pkg::CELL_EMPTY}, 1'b1,
                     '{16'd0, hlou_pkg::CELL_EMPTY, 16'd1, hlou_pkg::CELL_EMPTY,
                       17'd0, 17'd0}});
    plan.push_back('{'{hlou_pkg::CMD_LOAD, 8'd0, 8'd0, DIR_RIGHT, 16'd0,
                       hlou_pkg::CELL_RADICAL}, 1'b1,
                     '{16'd0, hlou_pkg::CELL_RADICAL, 16'd0, hlou_pkg::CELL_EMPTY,
                       17'd0, 17'd1}});
    plan.push_back('{'{hlou_pkg::CMD_LOAD, 8'd0, 8'd1, DIR_RIGHT, 16'd0,
                       hlou_pkg::CELL_MODERATE}, 1'b1,
                     '{16'd1, hlou_pkg::CELL_MODERATE, 16'd0, hlou_pkg::CELL_EMPTY,
                       17'd1, 17'd1}});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd0, 8'd0, DIR_RIGHT, 16'd0,
                       hlou_pkg::CELL_EMPTY}, 1'b1,
                     '{16'd0, hlou_pkg::CELL_RADICAL, 16'd1, hlou_pkg::CELL_RADICAL,
                       17'd0, 17'd2}});
    plan.push_back('{'{hlou_pkg::CMD_LOAD, 8'd255, 8'd255, DIR_RIGHT, 16'hFFFF,
                       hlou_pkg::CELL_INVALID}, 1'b1,
                     '{16'd16383, hlou_pkg::CELL_EMPTY, 16'd0, hlou_pkg::CELL_EMPTY,
                       17'd0, 17'd2}});
    plan.push_back('{'{hlou_pkg::CMD_LOAD, 8'd127, 8'd127, DIR_RIGHT, 16'd0,
                       hlou_pkg::CELL_MODERATE}, 1'b1,
                     '{16'd16383, hlou_pkg::CELL_MODERATE, 16'd0, hlou_pkg::CELL_EMPTY,
                       17'd1, 17'd2}});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd127, 8'd127, DIR_OVER_HI, 16'hFFFF,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd0, 8'd0, DIR_LEFT, 16'hFFFF,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd0, 8'd0, DIR_UP_LEFT, 16'd0,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd0, 8'd0, DIR_UP_RIGHT, 16'd19660,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd0, 8'd0, DIR_DOWN_LEFT, 16'd19661,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd0, 8'd0, DIR_DOWN_RIGHT, 16'h8000,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_LOAD, 8'd1, 8'd0, DIR_RIGHT, 16'd0,
                       hlou_pkg::CELL_RADICAL}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_LOAD, 8'd129, 8'd255, DIR_RIGHT, 16'd0,
                       hlou_pkg::CELL_MODERATE}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd1, 8'd0, DIR_LEFT, 16'd0,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd1, 8'd0, DIR_UP_RIGHT, 16'd100,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd1, 8'd0, DIR_UP_LEFT, 16'h7FFF,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd1, 8'd0, DIR_DOWN_LEFT, 16'h5555,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd1, 8'd0, DIR_DOWN_RIGHT, 16'hAAAA,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd1, 8'd0, DIR_OVER_LO, 16'd0,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd1, 8'd0, DIR_RIGHT, 16'hFFFF,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd1, 8'd127, DIR_RIGHT, 16'd0,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_UPDATE, 8'd0, 8'd2, DIR_LEFT, 16'd0,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});
    plan.push_back('{'{hlou_pkg::CMD_LOAD, 8'd0, 8'd0, DIR_RIGHT, 16'd0,
                       hlou_pkg::CELL_EMPTY}, 1'b0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table under the reset thresholds
    tx_gap_pct = 25;
    rx_stall_pct = 25;
    foreach (plan[i]) send_event(plan[i].ev, plan[i].typed, plan[i].want);

    run_phase(17'd19661, 17'd13107, 280, 30, 30);
    run_phase(17'd0, 17'd0, 260, 10, 40);
    run_phase(17'd65536, 17'd0, 260, 40, 10);
    run_phase(17'd0, 17'd65536, 260, 0, 0);
    run_phase(17'd65536, 17'd65536, 260, 20, 20);
    rnd_c = $urandom_range(0, 65536);
    rnd_m = $urandom_range(0, 65536);
    run_phase(rnd_c[16:0], rnd_m[16:0], 300, 30, 30);
    // closing stretch runs at full rate
    run_phase(17'd32768, 17'd40000, 300, 0, 0);

    in_valid <= 1'b0;
    guard = 0;
    while (pending_outcomes.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      fail_count += pending_outcomes.size();
      $display("%0d results never arrived", pending_outcomes.size());
    end

    $display("%0d events sent: %0d loads, %0d updates on occupied cells, %0d rule rewrites",
             events_sent, loads_seen, occupied_updates, rule_rewrites);
    $display("%0d results checked across %0d threshold settings", results_seen,
             settings_used + 1);
    if (fail_count == 0) begin
      $display("PASS hex_lattice_opinion_update");
    end else begin
      $display("FAIL hex_lattice_opinion_update");
    end
    $finish;
  end

endmodule
